FILE: hw/rtl/ssd_pkg.sv
// Shared constants, types and the segment decoder for the seven-segment display block.
package ssd_pkg;

  localparam int ValueW = 16;
  localparam int DigitW = 4;
  localparam int PosW   = 3;
  localparam int SegW   = 7;
  localparam int Radix  = 10;
  localparam int CntW   = $clog2(ValueW);

  localparam logic [PosW-1:0] FirstPos = PosW'(7);

  typedef struct packed {
    logic start;
    logic use_quot;
  } div_ctrl_t;

  function automatic logic [SegW-1:0] seg_decode(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

FILE: hw/rtl/ssd_div10.sv
// Bit-serial restoring divider by ten, one dividend bit per cycle.
module ssd_div10 (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ssd_pkg::div_ctrl_t               ctrl,
  input  logic [ssd_pkg::ValueW-1:0]       dividend,
  output logic                             done,
  output logic [ssd_pkg::ValueW-1:0]       quot,
  output logic [ssd_pkg::DigitW-1:0]       rem
);

  localparam logic [ssd_pkg::CntW-1:0] LastCnt = ssd_pkg::CntW'(ssd_pkg::ValueW - 1);
  localparam logic [ssd_pkg::DigitW:0] RadixW  = (ssd_pkg::DigitW + 1)'(ssd_pkg::Radix);

  logic [ssd_pkg::ValueW-1:0] quot_r, quot_nxt;
  logic [ssd_pkg::DigitW-1:0] rem_r, rem_nxt;
  logic [ssd_pkg::CntW-1:0]   cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [ssd_pkg::DigitW:0]   trial;
  logic                       ge;
  logic [ssd_pkg::DigitW:0]   diff;

  assign trial = {rem_r, quot_r[ssd_pkg::ValueW-1]};
  assign ge    = (trial >= RadixW);
  assign diff  = trial - RadixW;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      quot_nxt = ctrl.use_quot ? quot_r : dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[ssd_pkg::ValueW-2:0], ge};
      rem_nxt  = ge ? diff[ssd_pkg::DigitW-1:0] : trial[ssd_pkg::DigitW-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      busy_nxt = (cnt_r != LastCnt);
      done_nxt = (cnt_r == LastCnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

FILE: hw/rtl/seven_segment_decimal_display.sv
// Top level of the multiplexed seven-segment decimal display digit generator.
// A load transfer yields no result.
// A refresh yields one digit per bit-serial divide by ten (16 steps) plus capture, up to
// five digits; each divide starts at the refresh transfer or at the previous result transfer.
// One item is in work at a time; in_ready is low until the last digit is taken.
// Synchronous active-low reset clears the held value to zero and returns to idle.
module seven_segment_decimal_display (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [ssd_pkg::ValueW-1:0]    in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ssd_pkg::PosW-1:0]      out_position,
  output logic [ssd_pkg::SegW-1:0]      out_segments,
  output logic                          out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [ssd_pkg::ValueW-1:0]  shown_r, shown_nxt;
  logic [ssd_pkg::PosW-1:0]    pos_r, pos_nxt;
  logic [ssd_pkg::SegW-1:0]    seg_r, seg_nxt;
  logic                        last_r, last_nxt;
  logic                        in_xfer;
  logic                        out_xfer;
  ssd_pkg::div_ctrl_t          div_ctrl;
  logic                        div_done;
  logic [ssd_pkg::ValueW-1:0]  div_quot;
  logic [ssd_pkg::DigitW-1:0]  div_rem;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  assign div_ctrl.start    = (in_xfer && in_operation) || (out_xfer && !last_r);
  assign div_ctrl.use_quot = (state_r == ST_OUT);

  ssd_div10 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (shown_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    shown_nxt = shown_r;
    pos_nxt   = pos_r;
    seg_nxt   = seg_r;
    last_nxt  = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_operation) begin
            pos_nxt   = ssd_pkg::FirstPos;
            state_nxt = ST_DIV;
          end else begin
            shown_nxt = in_value;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          seg_nxt   = ssd_pkg::seg_decode(div_rem);
          last_nxt  = (div_quot == '0);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt   = pos_r - 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      shown_r <= '0;
    end else begin
      state_r <= state_nxt;
      shown_r <= shown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    seg_r  <= seg_nxt;
    last_r <= last_nxt;
  end

  assign out_position = pos_r;
  assign out_segments = seg_r;
  assign out_last     = last_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("Input and result channels are both open.");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("Divider finished outside of the divide state.");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last) |=> in_ready)
    else $error("Input not ready after the final digit transfer.");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_position >= ssd_pkg::PosW'(3)))
    else $error("Digit position beyond the fifth digit.");

  a_next_digit_divides: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !out_last) |=> (state_r == ST_DIV))
    else $error("No divide started for the next digit.");

endmodule

FILE: tb/tb_seven_segment_decimal_display.sv
// Self-checking testbench for the seven-segment decimal display digit generator.
`timescale 1ns / 100ps

module tb_seven_segment_decimal_display;

  localparam logic OpLoad    = 1'b0;
  localparam logic OpRefresh = 1'b1;
  localparam int   LongHold  = 300;
  localparam int   SettleCycles = 120;

  localparam logic [ssd_pkg::SegW-1:0] DigitSegments [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct {
    logic [ssd_pkg::PosW-1:0] position;
    logic [ssd_pkg::SegW-1:0] segments;
    logic                     last;
  } digit_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_operation;
  logic [ssd_pkg::ValueW-1:0]  in_value;
  logic                        out_valid;
  logic                        out_ready;
  logic [ssd_pkg::PosW-1:0]    out_position;
  logic [ssd_pkg::SegW-1:0]    out_segments;
  logic                        out_last;

  logic [ssd_pkg::ValueW-1:0]  model_value;
  digit_t                      expected_digits[$];
  int                          errors;
  bit                          no_idle;
  bit                          long_hold;

  seven_segment_decimal_display uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_position (out_position),
    .out_segments (out_segments),
    .out_last     (out_last)
  );

  always #4 clk = ~clk;

  function automatic void push_digit(input int pos, input int digit, input logic is_last);
    digit_t d;
    d.position = pos[ssd_pkg::PosW-1:0];
    d.segments = DigitSegments[digit];
    d.last     = is_last;
    expected_digits.push_back(d);
  endfunction

  function automatic void predict_digits(input logic op, input logic [ssd_pkg::ValueW-1:0] val);
    int unsigned low_group;
    int unsigned high_group;
    int unsigned digit;
    int          pos;
    if (op == OpLoad) begin
      model_value = val;
      return;
    end
    low_group  = model_value % 10000;
    high_group = model_value / 10000;
    if (model_value == 0) begin
      push_digit(7, 0, 1'b1);
      return;
    end
    pos = 7;
    while (low_group != 0 || high_group != 0) begin
      if (pos > 3) begin
        digit     = low_group % 10;
        low_group = low_group / 10;
      end else begin
        digit      = high_group % 10;
        high_group = high_group / 10;
      end
      push_digit(pos, digit, low_group == 0 && high_group == 0);
      if (pos == 0) begin
        break;
      end
      pos--;
    end
  endfunction

  task automatic send_item(input logic op, input logic [ssd_pkg::ValueW-1:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    do @(posedge clk); while (!in_ready);
    predict_digits(op, val);
  endtask

  task automatic show_value(input logic [ssd_pkg::ValueW-1:0] val);
    send_item(OpLoad, val);
    send_item(OpRefresh, ssd_pkg::ValueW'($urandom));
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_digits.size() > 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [ssd_pkg::ValueW-1:0] pick_value();
    int unsigned v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 65535);
      1: v = $urandom_range(0, 9);
      2: v = $urandom_range(0, 9999);
      3: v = $urandom_range(1, 6) * 10000 + $urandom_range(0, 20);
      4: v = $urandom_range(60000, 65535);
      default: begin
        v = 1;
        repeat ($urandom_range(0, 4)) v = v * 10;
        v = v + $urandom_range(0, 2) - 1;
      end
    endcase
    return ssd_pkg::ValueW'(v);
  endfunction

  task automatic test_reset_value();
    send_item(OpRefresh, 16'h0000);
  endtask

  task automatic test_value_extremes();
    show_value(16'd0);
    show_value(16'd7);
    show_value(16'd9999);
    show_value(16'd10000);
    show_value(16'd65535);
  endtask

  task automatic test_digit_patterns();
    show_value(16'd12340);
    show_value(16'd56789);
  endtask

  task automatic test_refresh_ignores_value();
    send_item(OpLoad, 16'd10);
    send_item(OpRefresh, 16'hFFFF);
    send_item(OpLoad, 16'd3);
    send_item(OpLoad, 16'd40005);
    send_item(OpRefresh, 16'h0000);
  endtask

  task automatic test_output_backpressure();
    wait_until_drained();
    no_idle   = 1'b1;
    long_hold = 1'b1;
    repeat (4) show_value(pick_value());
    wait_until_drained();
    no_idle = 1'b0;
  endtask

  task automatic test_pause_until_empty();
    show_value(16'd65535);
    wait_until_drained();
    show_value(pick_value());
    wait_until_drained();
    send_item(OpRefresh, pick_value());
    wait_until_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    logic op;
    logic last_was_load;
    last_was_load = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 30 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (last_was_load) begin
        op = ($urandom_range(0, 4) != 0) ? OpRefresh : OpLoad;
      end else begin
        op = ($urandom_range(0, 1) == 0) ? OpLoad : OpRefresh;
      end
      send_item(op, (op == OpLoad) ? pick_value() : ssd_pkg::ValueW'($urandom));
      last_was_load = (op == OpLoad);
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : digit_check
    digit_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected digit, expected none, actual pos %0d seg %h last %b",
                 $time, out_position, out_segments, out_last);
        errors++;
      end else begin
        want = expected_digits.pop_front();
        if (out_position !== want.position) begin
          $display("%0t: position mismatch, expected %0d actual %0d",
                   $time, want.position, out_position);
          errors++;
        end
        if (out_segments !== want.segments) begin
          $display("%0t: segments mismatch, expected %h actual %h",
                   $time, want.segments, out_segments);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch, expected %b actual %b", $time, want.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb_seven_segment_decimal_display NOT OK");
    $finish;
  end

  initial begin
    errors       = 0;
    no_idle      = 1'b0;
    long_hold    = 1'b0;
    model_value  = '0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OpLoad;
    in_value     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_value();
    test_value_extremes();
    test_digit_patterns();
    test_refresh_ignores_value();
    test_output_backpressure();
    test_pause_until_empty();
    test_random_traffic(240);
    wait_until_drained();
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb_seven_segment_decimal_display OK");
    end else begin
      $display("tb_seven_segment_decimal_display NOT OK");
    end
    $finish;
  end

endmodule
